@@ src/spbf_pkg.sv @@
// Shared types and constants for the shortest path block.
// Used by the controller, the datapath and the top level; no dependencies.
`timescale 1ns / 1ps

package spbf_pkg;

  // Graph size and number formats.
  localparam int MAX_VERTICES = 32;
  localparam int VIDX_BITS    = $clog2(MAX_VERTICES);
  localparam int CNT_BITS     = VIDX_BITS + 1;
  localparam int WEIGHT_BITS  = 16;
  localparam int DIST_BITS    = 24;
  localparam int WADDR_BITS   = 2 * VIDX_BITS;
  localparam int CFG_BITS     = 6;

  // This weight marks a missing edge; it is also the non-source start distance.
  localparam logic [DIST_BITS-1:0] NO_EDGE  = DIST_BITS'(32767);
  localparam logic [DIST_BITS-1:0] DIST_MAX = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam logic [DIST_BITS-1:0] DIST_MIN = {1'b1, {(DIST_BITS-1){1'b0}}};

  // Configuration register indexes.
  localparam logic REG_VERTEX_COUNT  = 1'b0;
  localparam logic REG_SOURCE_VERTEX = 1'b1;

  // Input item modes.
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  // Controller states, one-hot.
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_INIT = 6'b000010,
    S_VRD  = 6'b000100,
    S_URD  = 6'b001000,
    S_CMP  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic                 load_wr;
    logic                 init_wr;
    logic                 init_src;
    logic                 rd_v;
    logic                 latch_dv;
    logic                 relax;
    logic                 out_issue;
    logic                 out_last;
    logic [VIDX_BITS-1:0] v;
    logic [VIDX_BITS-1:0] u;
  } cmd_t;

endpackage

@@ src/shortest_path_bellman_ford.sv @@
// Bellman-Ford shortest paths: a load beat is taken while idle; busy stays low.
// A run with n vertices initialises n distances, makes n-1 passes relaxing
// each vertex pair through the registered weight and distance RAM reads, then
// sends n result beats on consecutive cycles; the receiver cannot stall.
// Synchronous reset returns to idle with vertex_count 32 and source_vertex 0.
// Depends on spbf_pkg, spbf_ctrl, spbf_dp and spbf_ram.
`timescale 1ns / 1ps

module shortest_path_bellman_ford (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              mode,
  input  logic [spbf_pkg::VIDX_BITS-1:0]    from_vertex,
  input  logic [spbf_pkg::VIDX_BITS-1:0]    to_vertex,
  input  logic signed [spbf_pkg::WEIGHT_BITS-1:0] weight,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic                              cfg_index,
  input  logic [spbf_pkg::CFG_BITS-1:0]     cfg_data,
  output logic                              result_valid,
  output logic [spbf_pkg::VIDX_BITS-1:0]    vertex,
  output logic signed [spbf_pkg::DIST_BITS-1:0] distance,
  output logic [spbf_pkg::VIDX_BITS-1:0]    predecessor,
  output logic                              last
);

  logic [spbf_pkg::CFG_BITS-1:0]  vertex_count;
  logic [spbf_pkg::VIDX_BITS-1:0] source_vertex;
  logic [spbf_pkg::CNT_BITS-1:0]  n_eff;
  spbf_pkg::cmd_t                 cmd;

  assign cfg_ready = 1'b1;

  // Configuration registers, written one beat at a time.
  always_ff @(posedge clk) begin
    if (rst) begin
      vertex_count  <= spbf_pkg::CFG_BITS'(spbf_pkg::MAX_VERTICES);
      source_vertex <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        spbf_pkg::REG_VERTEX_COUNT:  vertex_count  <= cfg_data;
        spbf_pkg::REG_SOURCE_VERTEX: source_vertex <= cfg_data[spbf_pkg::VIDX_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the vertex count to one through the maximum.
  always_comb begin
    if (vertex_count == '0) begin
      n_eff = spbf_pkg::CNT_BITS'(1);
    end else if (spbf_pkg::CNT_BITS'(vertex_count) >
                 spbf_pkg::CNT_BITS'(spbf_pkg::MAX_VERTICES)) begin
      n_eff = spbf_pkg::CNT_BITS'(spbf_pkg::MAX_VERTICES);
    end else begin
      n_eff = spbf_pkg::CNT_BITS'(vertex_count);
    end
  end

  spbf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .n_eff (n_eff),
    .source(source_vertex),
    .busy  (busy),
    .cmd   (cmd)
  );

  spbf_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .source      (source_vertex),
    .from_vertex (from_vertex),
    .to_vertex   (to_vertex),
    .weight      (weight),
    .result_valid(result_valid),
    .vertex      (vertex),
    .distance    (distance),
    .predecessor (predecessor),
    .last        (last)
  );

  // A result beat only follows a cycle of a run.
  a_result_in_run: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> $past(busy))
    else $error("result beat outside a run");

  // The last flag only rides on a result beat.
  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    last |-> result_valid)
    else $error("last without result beat");

  // Result beats of one run are contiguous until the last one.
  a_results_contiguous: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |=> result_valid)
    else $error("gap in result beats");

  // An accepted run makes the block busy.
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && mode == spbf_pkg::MODE_RUN) |=> busy)
    else $error("run accepted but block not busy");

endmodule

@@ src/spbf_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spbf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Read data registered; a read of the address being written returns the old data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/spbf_ctrl.sv @@
// Controller state machine: sequences init, relaxation passes and result sweep.
// Depends on spbf_pkg.
`timescale 1ns / 1ps

module spbf_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic                          mode,
  input  logic [spbf_pkg::CNT_BITS-1:0] n_eff,
  input  logic [spbf_pkg::VIDX_BITS-1:0] source,
  output logic                          busy,
  output spbf_pkg::cmd_t                cmd
);

  spbf_pkg::state_t state, state_next;
  logic [spbf_pkg::VIDX_BITS-1:0] v, v_next;
  logic [spbf_pkg::VIDX_BITS-1:0] u, u_next;
  logic [spbf_pkg::VIDX_BITS-1:0] pass_counter, pass_counter_next;
  logic [spbf_pkg::CNT_BITS-1:0]  n_run, n_run_next;
  logic [spbf_pkg::CNT_BITS-1:0]  n_last;
  logic                           u_end;
  logic                           v_end;
  logic                           accept;

  assign busy   = (state != spbf_pkg::S_IDLE);
  assign accept = start && !busy;
  assign n_last = n_run - spbf_pkg::CNT_BITS'(1);
  assign u_end  = ({1'b0, u} == n_last);
  assign v_end  = ({1'b0, v} == n_last);

  // Next state and counters.
  always_comb begin
    state_next        = state;
    v_next            = v;
    u_next            = u;
    pass_counter_next = pass_counter;
    n_run_next        = n_run;
    unique case (state)
      spbf_pkg::S_IDLE: begin
        if (accept && mode == spbf_pkg::MODE_RUN) begin
          state_next        = spbf_pkg::S_INIT;
          n_run_next        = n_eff;
          u_next            = '0;
          v_next            = '0;
          pass_counter_next = '0;
        end
      end
      spbf_pkg::S_INIT: begin
        if (u_end) begin
          u_next = '0;
          if (n_run == spbf_pkg::CNT_BITS'(1)) begin
            state_next = spbf_pkg::S_OUT;
          end else begin
            state_next = spbf_pkg::S_VRD;
          end
        end else begin
          u_next = u + spbf_pkg::VIDX_BITS'(1);
        end
      end
      spbf_pkg::S_VRD: begin
        state_next = spbf_pkg::S_URD;
      end
      spbf_pkg::S_URD: begin
        state_next = spbf_pkg::S_CMP;
      end
      spbf_pkg::S_CMP: begin
        if (u_end) begin
          u_next = '0;
          if (v_end) begin
            v_next            = '0;
            pass_counter_next = pass_counter + spbf_pkg::VIDX_BITS'(1);
            if ({1'b0, pass_counter_next} == n_last) begin
              state_next = spbf_pkg::S_OUT;
            end else begin
              state_next = spbf_pkg::S_VRD;
            end
          end else begin
            v_next     = v + spbf_pkg::VIDX_BITS'(1);
            state_next = spbf_pkg::S_VRD;
          end
        end else begin
          u_next     = u + spbf_pkg::VIDX_BITS'(1);
          state_next = spbf_pkg::S_URD;
        end
      end
      spbf_pkg::S_OUT: begin
        if (u_end) begin
          u_next     = '0;
          state_next = spbf_pkg::S_IDLE;
        end else begin
          u_next = u + spbf_pkg::VIDX_BITS'(1);
        end
      end
      default: begin
        state_next = spbf_pkg::S_IDLE;
      end
    endcase
  end

  // State and counter registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= spbf_pkg::S_IDLE;
      v            <= '0;
      u            <= '0;
      pass_counter <= '0;
      n_run        <= spbf_pkg::CNT_BITS'(spbf_pkg::MAX_VERTICES);
    end else begin
      state        <= state_next;
      v            <= v_next;
      u            <= u_next;
      pass_counter <= pass_counter_next;
      n_run        <= n_run_next;
    end
  end

  // Commands to the datapath.
  always_comb begin
    cmd           = '0;
    cmd.v         = v;
    cmd.u         = u;
    cmd.load_wr   = accept && (mode == spbf_pkg::MODE_LOAD);
    cmd.init_wr   = (state == spbf_pkg::S_INIT);
    cmd.init_src  = (u == source);
    cmd.rd_v      = (state == spbf_pkg::S_VRD);
    cmd.latch_dv  = (state == spbf_pkg::S_URD) && (u == '0);
    cmd.relax     = (state == spbf_pkg::S_CMP);
    cmd.out_issue = (state == spbf_pkg::S_OUT);
    cmd.out_last  = (state == spbf_pkg::S_OUT) && u_end;
  end

endmodule

@@ src/spbf_dp.sv @@
// Datapath: weight matrix, distance and predecessor stores, relaxation adder.
// Depends on spbf_pkg and spbf_ram.
`timescale 1ns / 1ps

module spbf_dp (
  input  logic                             clk,
  input  logic                             rst,
  input  spbf_pkg::cmd_t                   cmd,
  input  logic [spbf_pkg::VIDX_BITS-1:0]   source,
  input  logic [spbf_pkg::VIDX_BITS-1:0]   from_vertex,
  input  logic [spbf_pkg::VIDX_BITS-1:0]   to_vertex,
  input  logic signed [spbf_pkg::WEIGHT_BITS-1:0] weight,
  output logic                             result_valid,
  output logic [spbf_pkg::VIDX_BITS-1:0]   vertex,
  output logic signed [spbf_pkg::DIST_BITS-1:0] distance,
  output logic [spbf_pkg::VIDX_BITS-1:0]   predecessor,
  output logic                             last
);

  logic [spbf_pkg::WEIGHT_BITS-1:0] w_rd;
  logic [spbf_pkg::DIST_BITS-1:0]   d_rd;
  logic [spbf_pkg::VIDX_BITS-1:0]   p_rd;
  logic [spbf_pkg::DIST_BITS-1:0]   dv;
  logic signed [spbf_pkg::DIST_BITS:0] sum;
  logic [spbf_pkg::DIST_BITS-1:0]   cand;
  logic                             take;
  logic                             d_we;
  logic [spbf_pkg::VIDX_BITS-1:0]   d_raddr;
  logic [spbf_pkg::DIST_BITS-1:0]   d_wdata;
  logic [spbf_pkg::VIDX_BITS-1:0]   p_wdata;

  // Weight matrix, addressed by tail and head vertex.
  spbf_ram #(
    .WIDTH(spbf_pkg::WEIGHT_BITS),
    .DEPTH(spbf_pkg::MAX_VERTICES * spbf_pkg::MAX_VERTICES)
  ) u_weight_ram (
    .clk  (clk),
    .we   (cmd.load_wr),
    .waddr({from_vertex, to_vertex}),
    .wdata(weight),
    .raddr({cmd.v, cmd.u}),
    .rdata(w_rd)
  );

  // Candidate distance: weight plus distance of the tail, saturated.
  assign sum = $signed({{(spbf_pkg::DIST_BITS + 1 - spbf_pkg::WEIGHT_BITS){w_rd[spbf_pkg::WEIGHT_BITS-1]}},
                        w_rd})
             + $signed({dv[spbf_pkg::DIST_BITS-1], dv});

  always_comb begin
    if (sum[spbf_pkg::DIST_BITS] != sum[spbf_pkg::DIST_BITS-1]) begin
      cand = sum[spbf_pkg::DIST_BITS] ? spbf_pkg::DIST_MIN : spbf_pkg::DIST_MAX;
    end else begin
      cand = sum[spbf_pkg::DIST_BITS-1:0];
    end
  end

  assign take = cmd.relax && ($signed(d_rd) > $signed(cand));

  // Distance and predecessor write selection.
  assign d_we    = cmd.init_wr || take;
  assign d_wdata = cmd.init_wr ? (cmd.init_src ? '0 : spbf_pkg::NO_EDGE) : cand;
  assign p_wdata = cmd.init_wr ? source : cmd.v;
  assign d_raddr = cmd.rd_v ? cmd.v : cmd.u;

  spbf_ram #(
    .WIDTH(spbf_pkg::DIST_BITS),
    .DEPTH(spbf_pkg::MAX_VERTICES)
  ) u_dist_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(cmd.u),
    .wdata(d_wdata),
    .raddr(d_raddr),
    .rdata(d_rd)
  );

  spbf_ram #(
    .WIDTH(spbf_pkg::VIDX_BITS),
    .DEPTH(spbf_pkg::MAX_VERTICES)
  ) u_pred_ram (
    .clk  (clk),
    .we   (d_we),
    .waddr(cmd.u),
    .wdata(p_wdata),
    .raddr(cmd.u),
    .rdata(p_rd)
  );

  // Tail distance register; follows a self-loop update of the tail itself.
  always_ff @(posedge clk) begin
    if (cmd.latch_dv) begin
      dv <= d_rd;
    end else if (take && (cmd.u == cmd.v)) begin
      dv <= cand;
    end
  end

  // The result beat comes in the cycle after its read issue.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= cmd.out_issue;
    end
    vertex <= cmd.u;
    last   <= cmd.out_last;
  end

  assign distance    = d_rd;
  assign predecessor = p_rd;

endmodule
